>>> rtl/gssc_pkg.sv
// Package for the GIF stream structure scanner.
// Record kinds, display modes, marker bytes and the result beat type; no dependencies.
package gssc_pkg;

   typedef enum logic [3:0] {
      KIND_VERSION       = 4'd0,
      KIND_SCREEN        = 4'd1,
      KIND_COLOR         = 4'd2,
      KIND_IMAGE         = 4'd3,
      KIND_CODESIZE      = 4'd4,
      KIND_IMAGETOTAL    = 4'd5,
      KIND_EXTTOTAL      = 4'd6,
      KIND_UNEXPECTED    = 4'd7,
      KIND_NOTGIF        = 4'd8,
      KIND_EOFINBLOCK    = 4'd9,
      KIND_EOFBEFOREZERO = 4'd10,
      KIND_NOTERMINATOR  = 4'd11,
      KIND_TRUNCATED     = 4'd12
   } kind_type;

   localparam logic [1:0] MODE_PERCENT = 2'd1;
   localparam logic [1:0] MODE_HEX     = 2'd2;
   localparam logic [7:0] SIG_BYTE     = 8'h47;
   localparam logic [7:0] IMAGE_SEP    = 8'h2C;
   localparam logic [7:0] EXT_INTRO    = 8'h21;
   localparam logic [7:0] TRAILER      = 8'h3B;

   typedef struct packed {
      logic [3:0]  record_kind;
      logic [15:0] field_a;
      logic [15:0] field_b;
      logic [15:0] field_c;
      logic [15:0] field_d;
      logic [3:0]  bits_per_pixel;
      logic        map_present;
      logic        interlaced;
      logic        reserved_bits_error;
      logic        reserved_byte_error;
      logic [31:0] byte_total;
      logic [31:0] possible_total;
   } rec_type;

   // Scale a color component to percent of 255, truncated.
   function automatic logic [7:0] pct(input logic [7:0] v);
      logic [15:0] p;
      logic [15:0] q;
      p = 16'(v) * 16'd100;
      q = 16'((32'(p) * 32'd257) >> 16);
      if (p - q * 16'd255 >= 16'd255) q = q + 16'd1;
      return q[7:0];
   endfunction

endpackage

>>> rtl/gssc_if.sv
// Valid/ready stream interfaces for the scanner.
// Depends on gssc_pkg.
interface gssc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_file;
   modport source (output valid, data_byte, end_of_file, input ready);
   modport sink (input valid, data_byte, end_of_file, output ready);
endinterface

interface gssc_rsp_if import gssc_pkg::*; ;
   logic    valid;
   logic    ready;
   rec_type rec;
   modport source (output valid, rec, input ready);
   modport sink (input valid, rec, output ready);
endinterface

>>> rtl/gif_stream_structure_scanner_top.sv
// GIF stream structure scanner: one byte per beat, at most one record.
// Latency: a record appears the cycle after the byte that causes it.
// Throughput: one byte per cycle; the single output register refills in the
// cycle it is taken, so input stalls only while a record waits unread.
// Reset: synchronous, active high; clears parser state, mode goes to hex (2).
module gif_stream_structure_scanner_top
   import gssc_pkg::*;
#(
   parameter int COUNT_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   gssc_req_if.sink    req,
   gssc_rsp_if.source  rsp,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_write_data
);

   localparam logic [COUNT_BITS-1:0] CMAX = '1;

   typedef enum logic [3:0] {
      PH_SIG, PH_VERSION, PH_SCREEN, PH_GCOLOR, PH_TOP, PH_IMGDESC, PH_LCOLOR,
      PH_CODESIZE, PH_IMGCOUNT, PH_IMGDATA, PH_EXTCODE, PH_EXTCOUNT, PH_EXTDATA
   } phase_type;

   logic [1:0]  mode_ff;
   phase_type   phase_ff, phase_in;
   logic [3:0]  idx_ff, idx_in;
   logic [63:0] col_ff, col_in;
   logic [8:0]  crem_ff, crem_in;
   logic [7:0]  cidx_ff, cidx_in;
   logic [7:0]  brem_ff, brem_in;
   logic [COUNT_BITS-1:0] dtot_ff, dtot_in, unx_ff, unx_in;
   logic [15:0] imgn_ff, imgn_in;
   logic [3:0]  gbits_ff, gbits_in, ibits_ff, ibits_in;
   logic [31:0] area_ff, area_in;
   logic        term_ff, term_in, halt_ff, halt_in;
   logic        ovalid_ff;
   rec_type     orec_ff, rec;
   logic        emit;
   logic        accept;

   // Saturating add of a byte and 32-bit cap.
   function automatic logic [COUNT_BITS-1:0] sadd(input logic [COUNT_BITS-1:0] a,
                                                  input logic [7:0] b);
      logic [COUNT_BITS:0] s;
      s = {1'b0, a} + (COUNT_BITS+1)'(b);
      return s[COUNT_BITS] ? CMAX : s[COUNT_BITS-1:0];
   endfunction

   function automatic logic [31:0] cap(input logic [COUNT_BITS-1:0] v);
      logic [47:0] w;
      w = 48'(v);
      return (w > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
   endfunction

   function automatic logic [7:0] sc(input logic [1:0] m, input logic [7:0] v);
      return (m == MODE_PERCENT) ? pct(v) : v;
   endfunction

   assign req.ready = !ovalid_ff || rsp.ready;
   assign accept = req.valid && req.ready;

   // Parse one byte.
   always_comb begin
      logic [7:0] b;
      logic [7:0] pk;
      logic [3:0] bpp;
      logic [3:0] bits;
      b = req.data_byte;
      pk = col_ff[39:32];
      bpp = 4'd0;
      bits = 4'd0;
      phase_in = phase_ff; idx_in = idx_ff; col_in = col_ff; crem_in = crem_ff;
      cidx_in = cidx_ff; brem_in = brem_ff; dtot_in = dtot_ff; unx_in = unx_ff;
      imgn_in = imgn_ff; gbits_in = gbits_ff; ibits_in = ibits_ff; area_in = area_ff;
      term_in = term_ff; halt_in = halt_ff;
      rec = '0;
      emit = 1'b0;
      if (req.end_of_file) begin
         if (!halt_ff) begin
            unique case (phase_ff)
               PH_SIG: begin emit = 1'b1; rec.record_kind = KIND_NOTGIF; end
               PH_TOP: begin
                  if (!term_ff) begin
                     emit = 1'b1; rec.record_kind = KIND_NOTERMINATOR;
                  end else if (unx_ff != '0) begin
                     emit = 1'b1; rec.record_kind = KIND_UNEXPECTED;
                     rec.field_b = 16'd2; rec.byte_total = cap(unx_ff);
                  end
               end
               PH_IMGDATA, PH_IMGCOUNT, PH_EXTDATA, PH_EXTCOUNT: begin
                  emit = 1'b1;
                  rec.record_kind = (phase_ff == PH_IMGDATA || phase_ff == PH_EXTDATA)
                                    ? KIND_EOFINBLOCK : KIND_EOFBEFOREZERO;
                  rec.field_a = (phase_ff == PH_IMGDATA || phase_ff == PH_IMGCOUNT)
                                ? imgn_ff : {8'd0, col_ff[7:0]};
                  rec.byte_total = cap(dtot_ff);
               end
               default: begin emit = 1'b1; rec.record_kind = KIND_TRUNCATED; end
            endcase
         end
         phase_in = PH_SIG; idx_in = '0; col_in = '0; crem_in = '0; cidx_in = '0;
         brem_in = '0; dtot_in = '0; unx_in = '0; imgn_in = '0; gbits_in = '0;
         ibits_in = '0; area_in = '0; term_in = 1'b0; halt_in = 1'b0;
      end else if (!halt_ff) begin
         unique case (phase_ff)
            PH_SIG: begin
               if (b == SIG_BYTE) begin
                  phase_in = PH_VERSION; idx_in = '0; col_in = '0;
               end else begin
                  emit = 1'b1; rec.record_kind = KIND_NOTGIF; halt_in = 1'b1;
               end
            end
            PH_VERSION: begin
               if (idx_ff < 4'd4) begin
                  col_in[8*idx_ff[2:0] +: 8] = col_ff[8*idx_ff[2:0] +: 8] | b;
                  idx_in = idx_ff + 4'd1;
               end else begin
                  emit = 1'b1; rec.record_kind = KIND_VERSION;
                  rec.field_a = {col_ff[7:0], col_ff[15:8]};
                  rec.field_c = {col_ff[23:16], col_ff[31:24]};
                  rec.field_d = {8'd0, b};
                  phase_in = PH_SCREEN; idx_in = '0; col_in = '0;
               end
            end
            PH_SCREEN: begin
               if (idx_ff < 4'd6) begin
                  col_in[8*idx_ff[2:0] +: 8] = col_ff[8*idx_ff[2:0] +: 8] | b;
                  idx_in = idx_ff + 4'd1;
               end else begin
                  bpp = {1'b0, pk[2:0]} + 4'd1;
                  emit = 1'b1; rec.record_kind = KIND_SCREEN;
                  rec.field_a = col_ff[15:0]; rec.field_b = col_ff[31:16];
                  rec.field_c = {8'd0, col_ff[47:40]};
                  rec.field_d = {13'd0, pk[6:4]} + 16'd1;
                  rec.bits_per_pixel = bpp; rec.map_present = pk[7];
                  rec.reserved_bits_error = pk[3]; rec.reserved_byte_error = (b != 8'd0);
                  gbits_in = bpp;
                  if (pk[7]) begin
                     crem_in = 9'd1 << bpp; cidx_in = '0; idx_in = '0; col_in = '0;
                     phase_in = PH_GCOLOR;
                  end else begin
                     phase_in = PH_TOP;
                  end
               end
            end
            PH_GCOLOR, PH_LCOLOR: begin
               if (idx_ff < 4'd2) begin
                  col_in[8*idx_ff[2:0] +: 8] = col_ff[8*idx_ff[2:0] +: 8] | b;
                  idx_in = idx_ff + 4'd1;
               end else begin
                  emit = 1'b1; rec.record_kind = KIND_COLOR;
                  rec.field_a = {8'd0, cidx_ff};
                  rec.field_b = {8'd0, sc(mode_ff, col_ff[7:0])};
                  rec.field_c = {8'd0, sc(mode_ff, col_ff[15:8])};
                  rec.field_d = {8'd0, sc(mode_ff, b)};
                  cidx_in = cidx_ff + 8'd1;
                  if (crem_ff != '0) crem_in = crem_ff - 9'd1;
                  idx_in = '0; col_in = '0;
                  if (crem_ff <= 9'd1)
                     phase_in = (phase_ff == PH_GCOLOR) ? PH_TOP : PH_CODESIZE;
               end
            end
            PH_TOP: begin
               priority if (b == IMAGE_SEP) begin
                  if (imgn_ff != 16'hFFFF) imgn_in = imgn_ff + 16'd1;
                  if (unx_ff != '0) begin
                     emit = 1'b1; rec.record_kind = KIND_UNEXPECTED;
                     rec.field_a = imgn_in; rec.byte_total = cap(unx_ff);
                     unx_in = '0;
                  end
                  phase_in = PH_IMGDESC; idx_in = '0; col_in = '0;
               end else if (b == EXT_INTRO) begin
                  phase_in = PH_EXTCODE;
               end else if (b == TRAILER) begin
                  if (unx_ff != '0) begin
                     emit = 1'b1; rec.record_kind = KIND_UNEXPECTED;
                     rec.field_b = 16'd1; rec.byte_total = cap(unx_ff);
                     unx_in = '0;
                  end
                  term_in = 1'b1;
               end else begin
                  unx_in = sadd(unx_ff, 8'd1);
               end
            end
            PH_IMGDESC: begin
               if (idx_ff < 4'd8) begin
                  col_in[8*idx_ff[2:0] +: 8] = col_ff[8*idx_ff[2:0] +: 8] | b;
                  idx_in = idx_ff + 4'd1;
               end else begin
                  bpp = {1'b0, b[2:0]} + 4'd1;
                  emit = 1'b1; rec.record_kind = KIND_IMAGE;
                  rec.field_a = col_ff[15:0]; rec.field_b = col_ff[31:16];
                  rec.field_c = col_ff[47:32]; rec.field_d = col_ff[63:48];
                  rec.bits_per_pixel = bpp; rec.map_present = b[7];
                  rec.interlaced = b[6]; rec.reserved_bits_error = (b[5:3] != 3'd0);
                  area_in = col_ff[47:32] * col_ff[63:48];
                  ibits_in = b[7] ? bpp : gbits_ff;
                  if (b[7]) begin
                     crem_in = 9'd1 << bpp; cidx_in = '0; idx_in = '0; col_in = '0;
                     phase_in = PH_LCOLOR;
                  end else begin
                     phase_in = PH_CODESIZE;
                  end
               end
            end
            PH_CODESIZE: begin
               emit = 1'b1; rec.record_kind = KIND_CODESIZE;
               rec.field_a = {8'd0, b};
               rec.reserved_bits_error = (b < 8'd2) || (b > 8'd8);
               dtot_in = '0; phase_in = PH_IMGCOUNT;
            end
            PH_IMGCOUNT: begin
               if (b == 8'd0) begin
                  bits = (ibits_ff == 4'd0) ? 4'd1 : ibits_ff;
                  emit = 1'b1; rec.record_kind = KIND_IMAGETOTAL;
                  rec.field_a = imgn_ff; rec.byte_total = cap(dtot_ff);
                  // area / (8 / bits): divisor is 8,4,2 or 1 (bits 5..8 give 1)
                  unique case (bits)
                     4'd1:               rec.possible_total = area_ff >> 3;
                     4'd2:               rec.possible_total = area_ff >> 2;
                     4'd3, 4'd4:         rec.possible_total = area_ff >> 1;
                     default:            rec.possible_total = area_ff;
                  endcase
                  phase_in = PH_TOP;
               end else begin
                  brem_in = b; dtot_in = sadd(dtot_ff, b); phase_in = PH_IMGDATA;
               end
            end
            PH_EXTCODE: begin
               col_in = {56'd0, b}; dtot_in = '0; phase_in = PH_EXTCOUNT;
            end
            PH_EXTCOUNT: begin
               if (b == 8'd0) begin
                  emit = 1'b1; rec.record_kind = KIND_EXTTOTAL;
                  rec.field_a = {8'd0, col_ff[7:0]}; rec.byte_total = cap(dtot_ff);
                  phase_in = PH_TOP;
               end else begin
                  brem_in = b; dtot_in = sadd(dtot_ff, b); phase_in = PH_EXTDATA;
               end
            end
            PH_IMGDATA, PH_EXTDATA: begin
               if (brem_ff != 8'd0) brem_in = brem_ff - 8'd1;
               if (brem_ff <= 8'd1)
                  phase_in = (phase_ff == PH_IMGDATA) ? PH_IMGCOUNT : PH_EXTCOUNT;
            end
            default: phase_in = PH_SIG;
         endcase
      end
   end

   // Hold parser state and the result register; advance on each accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_HEX;
         phase_ff <= PH_SIG; idx_ff <= '0; col_ff <= '0; crem_ff <= '0; cidx_ff <= '0;
         brem_ff <= '0; dtot_ff <= '0; unx_ff <= '0; imgn_ff <= '0; gbits_ff <= '0;
         ibits_ff <= '0; area_ff <= '0; term_ff <= 1'b0; halt_ff <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) mode_ff <= csr_write_data;
         if (accept) begin
            phase_ff <= phase_in; idx_ff <= idx_in; col_ff <= col_in;
            crem_ff <= crem_in; cidx_ff <= cidx_in; brem_ff <= brem_in;
            dtot_ff <= dtot_in; unx_ff <= unx_in; imgn_ff <= imgn_in;
            gbits_ff <= gbits_in; ibits_ff <= ibits_in; area_ff <= area_in;
            term_ff <= term_in; halt_ff <= halt_in;
         end
         if (accept && emit) orec_ff <= rec;
         if (accept) ovalid_ff <= emit;
         else if (rsp.ready) ovalid_ff <= 1'b0;
      end
   end

   assign rsp.valid = ovalid_ff;
   assign rsp.rec = orec_ff;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |-> !req.ready)
      else $error("input taken while result stalled");
   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      accept && halt_ff && !req.end_of_file |=> !rsp.valid)
      else $error("record while halted");
   a_eof_rearm: assert property (@(posedge clock) disable iff (reset)
      accept && req.end_of_file |=> phase_ff == PH_SIG && !halt_ff)
      else $error("no rearm after end of file");
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.rec.record_kind <= KIND_TRUNCATED)
      else $error("bad record kind");

endmodule
